>>> sv/npmt_pkg.sv
package npmt_pkg;

  localparam int ADDR_W = 32;
  localparam int ID_W   = 4;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_MATCH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_SCAN,
    S_DONE
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic wr_en;
    logic rd_find;
    logic scan_issue;
    logic set_add;
    logic set_find;
    logic set_hit;
    logic out_load;
  } npmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    id_ok;
    logic    addr_zero;
    logic    scan_more;
    logic    hit;
    logic    out_free;
  } npmt_sts_t;

  // mask implied by the address class, /32 for class d and e
  function automatic logic [ADDR_W-1:0] class_mask(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    if (!a[31]) begin
      m = 32'hFF00_0000;
    end else if (a[31:30] == 2'b10) begin
      m = 32'hFFFF_0000;
    end else if (a[31:29] == 3'b110) begin
      m = 32'hFFFF_FF00;
    end else begin
      m = 32'hFFFF_FFFF;
    end
    return m;
  endfunction

  // lowest set bit isolated; a higher one means a shorter mask
  function automatic logic [ADDR_W-1:0] low_bit(input logic [ADDR_W-1:0] m);
    return m & (~m + 32'd1);
  endfunction

endpackage

>>> sv/npmt_ram.sv
module npmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/npmt_datapath.sv
module npmt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  npmt_pkg::npmt_cmd_t          cmd,
  output npmt_pkg::npmt_sts_t          sts,
  input  logic [1:0]                   in_opcode,
  input  logic [npmt_pkg::ADDR_W-1:0]  in_ip_address,
  input  logic [npmt_pkg::ADDR_W-1:0]  in_ip_mask,
  input  logic [npmt_pkg::ID_W-1:0]    in_entry_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [npmt_pkg::ID_W-1:0]    out_result_id,
  output logic [npmt_pkg::ADDR_W-1:0]  out_entry_prefix,
  output logic [npmt_pkg::ADDR_W-1:0]  out_entry_mask
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > npmt_pkg::ID_W) ? CNT_W : npmt_pkg::ID_W;
  localparam int AW     = npmt_pkg::ADDR_W;

  // latched request
  npmt_pkg::opcode_t         op_r;
  logic [AW-1:0]             addr_r;
  logic [AW-1:0]             mask_r;
  logic [AW-1:0]             if_low_r;
  logic [npmt_pkg::ID_W-1:0] id_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] eval_idx_r;
  logic             eval_valid_r;

  // pending result
  logic                      res_found_r;
  logic [npmt_pkg::ID_W-1:0] res_id_r;
  logic [AW-1:0]             res_pfx_r;
  logic [AW-1:0]             res_msk_r;

  // output register
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [npmt_pkg::ID_W-1:0] out_id_r;
  logic [AW-1:0]             out_pfx_r;
  logic [AW-1:0]             out_msk_r;

  logic [2*AW-1:0]   rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [WIDE_W-1:0] id_wide;
  logic [WIDE_W-1:0] count_wide;
  logic [WIDE_W-1:0] eval_wide;
  logic [AW-1:0]     ent_pfx;
  logic [AW-1:0]     ent_msk;
  logic [AW-1:0]     eff_msk;
  logic              covers;

  assign id_wide    = WIDE_W'(id_r);
  assign count_wide = WIDE_W'(count_r);
  assign eval_wide  = WIDE_W'(eval_idx_r);

  assign rd_addr = cmd.rd_find ? id_wide[IDX_W-1:0] : scan_idx_r[IDX_W-1:0];

  npmt_ram #(
    .WIDTH (2 * AW),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({mask_r, addr_r}),
    .rd_en   (cmd.rd_find | cmd.scan_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_pfx = rd_data[AW-1:0];
  assign ent_msk = rd_data[2*AW-1:AW];
  assign eff_msk = (ent_msk == '0) ? npmt_pkg::class_mask(ent_pfx) : ent_msk;

  // length check: entry length <= interface length, a zero interface mask only
  // admits a zero-length entry mask, which never occurs after the class fill
  assign covers = (ent_pfx == '0) ||
                  (((ent_pfx & eff_msk) == (addr_r & eff_msk)) &&
                   (if_low_r != '0) &&
                   (npmt_pkg::low_bit(eff_msk) >= if_low_r));

  assign sts.op        = op_r;
  assign sts.full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign sts.id_ok     = (id_wide < count_wide);
  assign sts.addr_zero = (addr_r == '0);
  assign sts.scan_more = (scan_idx_r < count_r);
  assign sts.hit       = eval_valid_r && covers;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= npmt_pkg::opcode_t'(in_opcode);
      addr_r   <= in_ip_address;
      mask_r   <= in_ip_mask;
      if_low_r <= npmt_pkg::low_bit(in_ip_mask);
      id_r     <= in_entry_id;
    end
    if (cmd.scan_issue) begin
      eval_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.accept) begin
      res_found_r <= 1'b0;
      res_id_r    <= '0;
      res_pfx_r   <= '0;
      res_msk_r   <= '0;
    end else if (cmd.set_add) begin
      res_found_r <= 1'b1;
      res_id_r    <= count_wide[npmt_pkg::ID_W-1:0];
    end else if (cmd.set_find) begin
      res_found_r <= 1'b1;
      res_pfx_r   <= ent_pfx;
      res_msk_r   <= ent_msk;
    end else if (cmd.set_hit) begin
      res_found_r <= 1'b1;
      res_id_r    <= eval_wide[npmt_pkg::ID_W-1:0];
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_id_r    <= res_id_r;
      out_pfx_r   <= res_pfx_r;
      out_msk_r   <= res_msk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      scan_idx_r   <= '0;
      eval_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.set_add) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.accept) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      eval_valid_r <= cmd.scan_issue;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_id    = out_id_r;
  assign out_entry_prefix = out_pfx_r;
  assign out_entry_mask   = out_msk_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.set_add |=> count_r == $past(count_r))
    else $error("entry count moved without an add");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= count_r)
    else $error("scan index past entry count");
`endif

endmodule

>>> sv/npmt_ctrl.sv
module npmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  npmt_pkg::npmt_sts_t sts,
  output npmt_pkg::npmt_cmd_t cmd
);

  npmt_pkg::ctl_state_t state_r;
  npmt_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npmt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      npmt_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = npmt_pkg::S_DECODE;
        end
      end
      npmt_pkg::S_DECODE: begin
        state_nxt = npmt_pkg::S_DONE;
        unique case (sts.op)
          npmt_pkg::OP_ADD: begin
            cmd.wr_en   = !sts.full;
            cmd.set_add = !sts.full;
          end
          npmt_pkg::OP_FIND: begin
            if (sts.id_ok) begin
              cmd.rd_find = 1'b1;
              state_nxt   = npmt_pkg::S_FIND;
            end
          end
          npmt_pkg::OP_MATCH: begin
            if (!sts.addr_zero) begin
              state_nxt = npmt_pkg::S_SCAN;
            end
          end
          npmt_pkg::OP_NONE: begin
            state_nxt = npmt_pkg::S_DONE;
          end
          default: begin
            state_nxt = npmt_pkg::S_DONE;
          end
        endcase
      end
      npmt_pkg::S_FIND: begin
        cmd.set_find = 1'b1;
        state_nxt    = npmt_pkg::S_DONE;
      end
      npmt_pkg::S_SCAN: begin
        if (sts.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = npmt_pkg::S_DONE;
        end else if (sts.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_nxt = npmt_pkg::S_DONE;
        end
      end
      npmt_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = npmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = npmt_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !sts.full)
    else $error("write issued to a full table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> sts.scan_more && !sts.hit)
    else $error("scan read past stored entries");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == npmt_pkg::S_DECODE)
    else $error("accepted request not decoded");
`endif

endmodule

>>> sv/network_prefix_match_table_top.sv
// from request accept through decode to the output register: add writes the store, find
// reads the entry by id, match scans until a hit or the last entry (zero address: no scan)
// the match scan reads the entry store once per cycle through its single registered port
// one request at a time, the next taken once the previous result is in the output register
// a new request is taken while the previous result still waits in the output register
// synchronous active-low reset empties the table and the output; entry store is not cleared
module network_prefix_match_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // ip_address [31:0], ip_mask [63:32], entry_id [67:64]
  input  logic [1:0]  in_tuser,   // opcode [1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // found [0], result_id [4:1], entry_prefix [36:5],
                                  // entry_mask [68:37]
);

  npmt_pkg::npmt_cmd_t cmd;
  npmt_pkg::npmt_sts_t sts;

  logic                          found;
  logic [npmt_pkg::ID_W-1:0]     result_id;
  logic [npmt_pkg::ADDR_W-1:0]   entry_prefix;
  logic [npmt_pkg::ADDR_W-1:0]   entry_mask;

  // sequencer: decode, store write, find read and match scan
  npmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry store, match compare and result registers
  npmt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_tuser),
    .in_ip_address    (in_tdata[31:0]),
    .in_ip_mask       (in_tdata[63:32]),
    .in_entry_id      (in_tdata[67:64]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_found        (found),
    .out_result_id    (result_id),
    .out_entry_prefix (entry_prefix),
    .out_entry_mask   (entry_mask)
  );

  // pack result fields, upper pad bits held at zero
  assign out_tdata = {3'b000, entry_mask, entry_prefix, result_id, found};

endmodule
